// ===== src/stbs_pkg.sv =====
package stbs_pkg;

   // field widths fixed by the interface
   localparam int COUNT_W = 11;
   localparam int POS_W   = 10;
   localparam int DATA_W  = 32;
   // wide enough for any table address and for the largest table depth
   localparam int WIDE_W  = 17;

   // operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic write;   // load transfer: write one table entry
      logic start;   // search transfer: open the range, latch the target
      logic read;    // read the midpoint entry
      logic step;    // narrow the range after a miss
      logic hit;     // record a match
      logic emit;    // move the result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;     // search range is empty
      logic match;     // probed entry equals the target
      logic out_busy;  // output register holds a result that is stalled
   } status_type;

endpackage

// ===== src/stbs_ctrl.sv =====
module stbs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_operation,
   output logic                req_stall,
   input  stbs_pkg::status_type status,
   output stbs_pkg::cmd_type    cmd
);
   import stbs_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // input side is open only between searches
   assign req_stall = (state_ff != ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_SEARCH) begin
                  cmd.start = 1'b1;
                  state_in  = ST_PROBE;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_PROBE: begin
            if (status.empty) begin
               state_in = ST_FINISH;
            end else begin
               cmd.read = 1'b1;
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (status.match) begin
               cmd.hit  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_PROBE;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/stbs_datapath.sv =====
module stbs_datapath #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [stbs_pkg::POS_W-1:0]            req_entry_index,
   input  logic signed [stbs_pkg::DATA_W-1:0]    req_data_value,
   input  logic                                  csr_write_enable,
   input  logic [stbs_pkg::COUNT_W-1:0]          csr_write_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic [stbs_pkg::POS_W-1:0]            rsp_position,
   input  stbs_pkg::cmd_type                     cmd,
   output stbs_pkg::status_type                  status
);
   import stbs_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic signed [DATA_W-1:0] table_mem [TABLE_DEPTH];

   logic [COUNT_W-1:0]       entry_count_ff;
   logic [COUNT_W-1:0]       count_sat;
   logic [COUNT_W-1:0]       low_ff;
   logic [COUNT_W-1:0]       high_ff;     // one past the last entry in range
   logic [COUNT_W-1:0]       mid;
   logic [COUNT_W-1:0]       mid_ff;
   logic signed [DATA_W-1:0] target_ff;
   logic signed [DATA_W-1:0] rdata_ff;
   logic                     found_ff;
   logic                     rsp_valid_ff;
   logic                     rsp_found_ff;
   logic [POS_W-1:0]         rsp_position_ff;
   logic [WIDE_W-1:0]        wr_wide;
   logic [WIDE_W-1:0]        rd_wide;
   logic [ADDR_W-1:0]        wr_addr;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     wr_in_range;

   // entry count register
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_write_enable) begin
         entry_count_ff <= csr_write_data;
      end
   end

   // count saturates at the table depth
   assign count_sat = (WIDE_W'(entry_count_ff) > WIDE_W'(TABLE_DEPTH))
                      ? COUNT_W'(TABLE_DEPTH) : entry_count_ff;

   // table addresses
   assign wr_wide     = WIDE_W'(req_entry_index);
   assign wr_addr     = wr_wide[ADDR_W-1:0];
   assign wr_in_range = (wr_wide < WIDE_W'(TABLE_DEPTH));
   assign rd_wide     = WIDE_W'(mid);
   assign rd_addr     = rd_wide[ADDR_W-1:0];

   // table write port
   always_ff @(posedge clock) begin
      if (cmd.write && wr_in_range) begin
         table_mem[wr_addr] <= req_data_value;
      end
   end

   // table read port
   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rdata_ff <= table_mem[rd_addr];
      end
   end

   // midpoint, rounding toward the low end
   assign mid = low_ff + ((high_ff - low_ff - COUNT_W'(1)) >> 1);

   // search range and probe bookkeeping
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         low_ff    <= '0;
         high_ff   <= count_sat;
         target_ff <= req_data_value;
         found_ff  <= 1'b0;
      end else begin
         if (cmd.read) begin
            mid_ff <= mid;
         end
         if (cmd.step) begin
            // larger entry means the target lies to the right
            if (rdata_ff > target_ff) begin
               low_ff <= mid_ff + COUNT_W'(1);
            end else begin
               high_ff <= mid_ff;
            end
         end
         if (cmd.hit) begin
            found_ff <= 1'b1;
         end
      end
   end

   assign status.empty    = (low_ff >= high_ff);
   assign status.match    = (rdata_ff == target_ff);
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff    <= found_ff;
         rsp_position_ff <= found_ff ? mid_ff[POS_W-1:0] : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

// ===== src/sorted_table_binary_search.sv =====
// Binary search over a table of signed 32-bit words held in a single-port-write,
// registered-read memory. A load transfer (operation 0) writes one entry in the
// cycle it is taken and the block is ready again in the next cycle; loads with an
// index at or beyond TABLE_DEPTH are dropped. A search transfer (operation 1)
// looks for data_value among the first entry_count entries (capped at
// TABLE_DEPTH), taking the table as non-increasing, and gives one result: found
// and the matching position, or found 0 with position 0. Each probe is one memory
// read followed by one compare, and a search makes at most floor(log2(n)) + 1
// probes for n entries in use. The result enters the output register at the same
// edge at which the input opens again, so the next transfer can be taken while
// that result is first offered. The input stalls while a search is running; a
// finished result waits in the output register without holding off the next
// load, but a search that ends while the previous result is still stalled holds
// in its last state until that result moves. Write entry_count only while idle.
module sorted_table_binary_search #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic [stbs_pkg::POS_W-1:0]            req_entry_index,
   input  logic signed [stbs_pkg::DATA_W-1:0]    req_data_value,
   input  logic                                  csr_write_enable,
   input  logic [stbs_pkg::COUNT_W-1:0]          csr_write_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic [stbs_pkg::POS_W-1:0]            rsp_position
);
   import stbs_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   stbs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // table, search range and output register
   stbs_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_entry_index  (req_entry_index),
      .req_data_value   (req_data_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== src/stbs_checker.sv =====
module stbs_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  req_operation,
   input logic [stbs_pkg::POS_W-1:0]            req_entry_index,
   input logic signed [stbs_pkg::DATA_W-1:0]    req_data_value,
   input logic                                  csr_write_enable,
   input logic [stbs_pkg::COUNT_W-1:0]          csr_write_data,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_found,
   input logic [stbs_pkg::POS_W-1:0]            rsp_position
);
   import stbs_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position))
      else $error("stalled result changed");

   // a miss reports position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss with nonzero position");

   // a search transfer blocks the input for the search
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation == OP_SEARCH |=> req_stall)
      else $error("input open right after search transfer");

   // a load transfer leaves the input open
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_operation == OP_LOAD |=> !req_stall)
      else $error("load transfer stalled the input");

   // a new result only comes out of a running search
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a running search");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);
